// ===== rtl/core/one_mismatch_substring_search_assert.svh =====
// Assertion helpers for the one-mismatch search block.
`ifndef ONE_MISMATCH_SUBSTRING_SEARCH_ASSERT_SVH
`define ONE_MISMATCH_SUBSTRING_SEARCH_ASSERT_SVH

// Clocked check, off while reset is high.
`define OMSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define OMSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/omss_pkg.sv =====
package omss_pkg;

   localparam int SYMBOL_W = 8;
   localparam int START_W  = 17;
   localparam int CNT_W    = 2;

   localparam int MAX_PATTERN_DEFAULT = 32;
   localparam int MAX_TEXT_DEFAULT    = 65536;

   localparam logic MODE_PATTERN = 1'b0;
   localparam logic MODE_TEXT    = 1'b1;

   // mismatch counts stop here
   localparam logic [CNT_W-1:0] CNT_SAT = 2'd2;
   // largest count that still counts as a hit
   localparam logic [CNT_W-1:0] CNT_HIT_MAX = 2'd1;

   // "no hit" index, -1 in 17 bits
   localparam logic signed [START_W-1:0] START_NONE = '1;

   // alignment handed from one cell to the next
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] cnt;
   } link_type;

   // per-cell controls for one item
   typedef struct packed {
      logic advance;
      logic flush;
      logic load;
   } ctl_type;

endpackage

// ===== rtl/core/omss_cell.sv =====
// One alignment stage: holds one pattern symbol, compares it with the
// incoming text symbol and passes the updated count on.
module omss_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  omss_pkg::ctl_type             ctl,
   input  logic [omss_pkg::SYMBOL_W-1:0] load_symbol,
   input  logic [omss_pkg::SYMBOL_W-1:0] text_symbol,
   input  logic                          tail_sel,
   input  omss_pkg::link_type            prev_link,
   output omss_pkg::link_type            next_link,
   output logic                          hit
);

   logic [omss_pkg::SYMBOL_W-1:0] pat_ff;
   omss_pkg::link_type            link_ff;
   omss_pkg::link_type            link_in;

   always_comb begin
      link_in.valid = prev_link.valid;
      if (prev_link.cnt != omss_pkg::CNT_SAT && text_symbol != pat_ff) begin
         link_in.cnt = prev_link.cnt + 1'b1;
      end else begin
         link_in.cnt = prev_link.cnt;
      end
   end

   // alignment finishes here when this is the pattern's last position
   assign hit = tail_sel && link_in.valid && (link_in.cnt <= omss_pkg::CNT_HIT_MAX);

   always_ff @(posedge clock) begin
      if (reset || ctl.flush) begin
         link_ff.valid <= 1'b0;
      end else if (ctl.advance) begin
         link_ff.valid <= link_in.valid;
      end
      if (ctl.advance) begin
         link_ff.cnt <= link_in.cnt;
      end
      if (ctl.load) begin
         pat_ff <= load_symbol;
      end
   end

   assign next_link = link_ff;

endmodule

// ===== rtl/core/one_mismatch_substring_search.sv =====
// Channel  | Ports                                                      | Direction
// ---------+------------------------------------------------------------+----------
// req      | req_valid req_stall req_mode req_symbol req_last           | in
// rsp      | rsp_valid rsp_stall rsp_start_index rsp_found              | out
//
// One item per cycle when no result is held under rsp_stall, pattern or text;
// a result is registered and shows in the cycle after the text item that causes it.
// Reset (synchronous) clears pattern length, closed flag and search state;
// pattern symbols are kept only as written.
// A result held under rsp_stall stalls the request side; nothing else stalls.
module one_mismatch_substring_search #(
   parameter int MAX_PATTERN = omss_pkg::MAX_PATTERN_DEFAULT,
   parameter int MAX_TEXT    = omss_pkg::MAX_TEXT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [omss_pkg::SYMBOL_W-1:0]       req_symbol,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [omss_pkg::START_W-1:0] rsp_start_index,
   output logic                                rsp_found
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int POS_W = $clog2(MAX_TEXT + 1);
   // room for the start index arithmetic
   localparam int SUM_W = (POS_W > omss_pkg::START_W) ? POS_W : omss_pkg::START_W;

   logic [LEN_W-1:0] pattern_length_ff, pattern_length_in;
   logic             pattern_closed_ff, pattern_closed_in;
   logic [POS_W-1:0] text_position_ff, text_position_in;
   logic             hit_seen_ff, hit_seen_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [omss_pkg::START_W-1:0] rsp_start_index_ff, rsp_start_index_in;
   logic                                rsp_found_ff, rsp_found_in;

   logic             accept;
   logic             pat_step;
   logic             text_step;
   logic             advance;
   logic             flush;
   logic             hit;
   logic [LEN_W-1:0] wr_base;
   logic             wr_ok;
   logic [SUM_W-1:0] hit_index;

   omss_pkg::link_type           links [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0]       cell_hit;

   // ---------------------------------------------------------------
   // Handshake: take an item unless a result is stuck in the output.
   // ---------------------------------------------------------------
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pat_step  = accept && (req_mode == omss_pkg::MODE_PATTERN);
   // text before the pattern is closed is dropped silently
   assign text_step = accept && (req_mode == omss_pkg::MODE_TEXT) && pattern_closed_ff
                      && (pattern_length_ff != '0);
   // past the text limit symbols no longer enter the row
   assign advance   = text_step && (text_position_ff < POS_W'(MAX_TEXT));

   // a new pattern after a closed one starts over from slot zero
   assign wr_base = pattern_closed_ff ? '0 : pattern_length_ff;
   assign wr_ok   = wr_base < LEN_W'(MAX_PATTERN);

   assign flush = (pat_step && pattern_closed_ff) || (text_step && req_last);

   // ---------------------------------------------------------------
   // Cell row: cell i holds the alignment that started i symbols ago.
   // ---------------------------------------------------------------
   assign links[0].valid = 1'b1;
   assign links[0].cnt   = '0;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      omss_pkg::ctl_type ctl;
      logic              tail_sel;

      assign ctl.advance = advance;
      assign ctl.flush   = flush;
      assign ctl.load    = pat_step && wr_ok && (wr_base == LEN_W'(i));
      assign tail_sel    = (pattern_length_ff == LEN_W'(i + 1));

      omss_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .load_symbol (req_symbol),
         .text_symbol (req_symbol),
         .tail_sel    (tail_sel),
         .prev_link   (links[i]),
         .next_link   (links[i+1]),
         .hit         (cell_hit[i])
      );
   end

   // only the first hit of a text run is reported
   assign hit = advance && !hit_seen_ff && (|cell_hit);

   // start = position - (length - 1)
   assign hit_index = SUM_W'(text_position_ff) - SUM_W'(pattern_length_ff) + SUM_W'(1);

   // ---------------------------------------------------------------
   // Search and pattern bookkeeping
   // ---------------------------------------------------------------
   always_comb begin
      pattern_length_in = pattern_length_ff;
      pattern_closed_in = pattern_closed_ff;
      text_position_in  = text_position_ff;
      hit_seen_in       = hit_seen_ff;

      if (pat_step) begin
         pattern_length_in = wr_ok ? wr_base + 1'b1 : wr_base;
         pattern_closed_in = req_last;
      end

      if (flush) begin
         text_position_in = '0;
         hit_seen_in      = 1'b0;
      end else begin
         if (advance) begin
            text_position_in = text_position_ff + 1'b1;
         end
         if (hit) begin
            hit_seen_in = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   always_comb begin
      priority if (hit) begin
         rsp_valid_in       = 1'b1;
         rsp_start_index_in = hit_index[omss_pkg::START_W-1:0];
         rsp_found_in       = 1'b1;
      end else if (text_step && req_last && !hit_seen_ff) begin
         rsp_valid_in       = 1'b1;
         rsp_start_index_in = omss_pkg::START_NONE;
         rsp_found_in       = 1'b0;
      end else begin
         rsp_valid_in       = rsp_valid_ff && rsp_stall;
         rsp_start_index_in = rsp_start_index_ff;
         rsp_found_in       = rsp_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_closed_ff <= 1'b0;
         text_position_ff  <= '0;
         hit_seen_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         pattern_closed_ff <= pattern_closed_in;
         text_position_ff  <= text_position_in;
         hit_seen_ff       <= hit_seen_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_start_index_ff <= rsp_start_index_in;
      rsp_found_ff       <= rsp_found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_index = rsp_start_index_ff;
   assign rsp_found       = rsp_found_ff;

endmodule

// ===== rtl/core/omss_checker.sv =====
`include "one_mismatch_substring_search_assert.svh"

module omss_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_mode,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [omss_pkg::START_W-1:0] rsp_start_index,
   input logic                                rsp_found
);

   // a miss always carries the "none" index
   `OMSS_ASSERT(a_miss_index, clock, reset, rsp_valid && !rsp_found |-> rsp_start_index == omss_pkg::START_NONE, "miss result without -1 index")

   // a new result follows an accepted text item
   `OMSS_ASSERT(a_rsp_cause, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_mode == omss_pkg::MODE_TEXT), "result without a text item")

   // request side stalls only behind a held result
   `OMSS_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "request stalled with output free")

   // result comes out of reset empty
   `OMSS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // held result keeps its payload
   `OMSS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_start_index) && $stable(rsp_found), "stalled result changed")

endmodule

bind one_mismatch_substring_search omss_checker u_omss_checker (.*);

// ===== tb/sv/tb_one_mismatch_substring_search.sv =====
module tb_one_mismatch_substring_search;
   timeunit 1ns;
   timeprecision 1ps;

   // Block sizes used for this build; they match the RTL defaults.
   localparam int PAT_CAP      = 32;
   localparam int TEXT_CAP     = 65536;
   // Target number of random items that the block actually acts on.
   localparam int RANDOM_ITEMS = 1000;
   // Items taken between drains in the random part.
   localparam int DRAIN_EVERY  = 150;

   typedef logic [omss_pkg::SYMBOL_W-1:0] sym_type;
   typedef sym_type sym_queue_type [$];

   // One search report: hit index (or none) plus the found flag.
   typedef struct {
      logic signed [omss_pkg::START_W-1:0] index;
      logic                                found;
   } report_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_mode;
   sym_type                             req_symbol;
   logic                                req_last;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [omss_pkg::START_W-1:0] rsp_start_index;
   logic                                rsp_found;

   one_mismatch_substring_search #(
      .MAX_PATTERN(PAT_CAP),
      .MAX_TEXT   (TEXT_CAP)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_symbol     (req_symbol),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_start_index(rsp_start_index),
      .rsp_found      (rsp_found)
   );

   // -------------------------------------------------------------------------
   // Shadow of the search engine state
   // -------------------------------------------------------------------------
   sym_type        pat_mem  [PAT_CAP];
   int unsigned    pat_len;
   bit             pat_closed;
   logic [omss_pkg::CNT_W-1:0] miss_cnt [PAT_CAP];
   int unsigned    text_pos;
   bit             hit_seen;

   // Reports predicted but not yet returned by the block, oldest first.
   report_type     pending_reports [$];

   // Run bookkeeping
   int unsigned    errors;
   int unsigned    items_taken;
   int unsigned    reports_checked;
   int unsigned    hits_checked;
   int unsigned    misses_checked;
   // When set, neither side inserts idle or stall cycles.
   bit             quiet;

   function automatic void clear_search();
      for (int k = 0; k < PAT_CAP; k++) miss_cnt[k] = '0;
      text_pos = 0;
      hit_seen = 0;
   endfunction

   // Advance the shadow by one accepted item and queue any report it causes.
   // Returns 0 when the block ignores the item (text with no closed pattern).
   function automatic bit search_step(logic mode, sym_type sym, logic fin);
      int unsigned m;
      int unsigned p;
      int unsigned d;
      bit          hit;
      int unsigned hit_at;
      report_type  rep;
      hit    = 0;
      hit_at = 0;
      if (mode == omss_pkg::MODE_PATTERN) begin
         // a pattern symbol after close starts a fresh pattern
         if (pat_closed) begin
            pat_len    = 0;
            pat_closed = 0;
            clear_search();
         end
         // symbols past capacity are dropped, last still closes
         if (pat_len < PAT_CAP) begin
            pat_mem[pat_len] = sym;
            pat_len++;
         end
         if (fin) pat_closed = 1;
         return 1;
      end
      if (!pat_closed || pat_len == 0) return 0;
      m = pat_len;
      p = text_pos;
      // past the text limit symbols no longer feed any alignment
      if (p < TEXT_CAP) begin
         miss_cnt[p % m] = '0;
         for (int k = 0; k < m; k++) begin
            // offset of this symbol inside the alignment held in cell k
            d = (p + m - k) % m;
            if (d > p) continue;
            if (pat_mem[d] != sym && miss_cnt[k] < omss_pkg::CNT_SAT) miss_cnt[k]++;
            if (d == m - 1 && miss_cnt[k] <= omss_pkg::CNT_HIT_MAX && !hit_seen && !hit) begin
               hit    = 1;
               hit_at = p - d;
            end
         end
         text_pos = p + 1;
      end
      if (hit) begin
         hit_seen  = 1;
         rep.index = hit_at[omss_pkg::START_W-1:0];
         rep.found = 1'b1;
         pending_reports.push_back(rep);
         if (fin) clear_search();
      end else if (fin) begin
         if (!hit_seen) begin
            rep.index = omss_pkg::START_NONE;
            rep.found = 1'b0;
            pending_reports.push_back(rep);
         end
         clear_search();
      end
      return 1;
   endfunction

   // Idle/stall draw shared by both sides: often zero, otherwise 0..16.
   function automatic int unsigned draw_wait();
      if (quiet) return 0;
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   // -------------------------------------------------------------------------
   // Clock, reset
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Sender: one item per call. Called and returns on a falling edge, with
   // valid low. Payload only changes while valid is low or after acceptance.
   // -------------------------------------------------------------------------
   task automatic send_item(input logic mode, input sym_type sym, input logic fin);
      int unsigned gap;
      gap = draw_wait();
      repeat (gap) @(negedge clock);
      req_mode   = mode;
      req_symbol = sym;
      req_last   = fin;
      req_valid  = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      // accepted at this edge
      if (search_step(mode, sym, fin)) items_taken++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Send a run of symbols in one mode, last flag on the final one if asked.
   task automatic send_run(input logic mode, input sym_queue_type syms, input bit close);
      for (int i = 0; i < syms.size(); i++)
         send_item(mode, syms[i], close && (i == syms.size() - 1));
   endtask

   // Hold the sender off until every predicted report has come back.
   task automatic drain_reports();
      while (pending_reports.size() != 0) @(negedge clock);
      // let the pipe settle past any item that produced no report
      repeat (4) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: before each report, stall for a drawn number of cycles.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = draw_wait();
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Report checker: every accepted report against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected report: expected none, got start_index %0d found %0b",
                     $time, rsp_start_index, rsp_found);
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (want.found) hits_checked++;
            else misses_checked++;
            if (rsp_start_index !== want.index) begin
               errors++;
               $display("%0t: start_index mismatch: expected %0d, got %0d",
                        $time, want.index, rsp_start_index);
            end
            if (rsp_found !== want.found) begin
               errors++;
               $display("%0t: found mismatch: expected %0b, got %0b",
                        $time, want.found, rsp_found);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Hand-picked sequences: text with no pattern, exact and one-off hits,
   // hit on the last symbol, report suppression after a hit, short text,
   // no-hit text, new pattern mid-text, text while a pattern is still open.
   task automatic test_directed_cases();
      sym_queue_type q;
      // text before any pattern exists: ignored even with last
      send_item(omss_pkg::MODE_TEXT, 8'h55, 1'b1);
      q = '{8'h00, 8'hFF, 8'h80};
      send_run(omss_pkg::MODE_PATTERN, q, 1);
      // exact window at 1, found on the last symbol
      q = '{8'hFF, 8'h00, 8'hFF, 8'h80};
      send_run(omss_pkg::MODE_TEXT, q, 1);
      // hit at 0, trailing symbols and last give nothing more
      q = '{8'h00, 8'hFF, 8'h80, 8'h11, 8'h22};
      send_run(omss_pkg::MODE_TEXT, q, 1);
      // text shorter than the pattern
      send_item(omss_pkg::MODE_TEXT, 8'h00, 1'b1);
      // every window has two or more mismatches
      q = '{8'h11, 8'h22, 8'h80, 8'h00};
      send_run(omss_pkg::MODE_TEXT, q, 1);
      // abandoned text, then a new pattern left open
      q = '{8'h00, 8'hFF};
      send_run(omss_pkg::MODE_TEXT, q, 0);
      send_item(omss_pkg::MODE_PATTERN, 8'h55, 1'b0);
      // text while the pattern is still open is dropped
      send_item(omss_pkg::MODE_TEXT, 8'h55, 1'b1);
      send_item(omss_pkg::MODE_PATTERN, 8'h7F, 1'b1);
      // one mismatch in the only window, hit on last
      q = '{8'h01, 8'h7F};
      send_run(omss_pkg::MODE_TEXT, q, 1);
      // two mismatches: no hit
      q = '{8'h00, 8'hFF};
      send_run(omss_pkg::MODE_TEXT, q, 1);
      drain_reports();
   endtask

   // Pattern longer than the store: extra symbols dropped, last still closes.
   task automatic test_pattern_overflow();
      sym_queue_type pat;
      sym_queue_type txt;
      int unsigned   pos;
      for (int i = 0; i < PAT_CAP + 8; i++) pat.push_back(sym_type'($urandom));
      send_run(omss_pkg::MODE_PATTERN, pat, 1);
      // stored part with one symbol altered: hit at 0
      for (int i = 0; i < PAT_CAP; i++) txt.push_back(pat[i]);
      pos = $urandom_range(0, PAT_CAP - 1);
      txt[pos] = txt[pos] ^ sym_type'($urandom_range(1, 255));
      send_run(omss_pkg::MODE_TEXT, txt, 1);
      // shifted copy with two alterations
      txt.delete();
      for (int i = 0; i < 5; i++) txt.push_back(sym_type'($urandom));
      for (int i = 0; i < PAT_CAP; i++) txt.push_back(pat[i]);
      txt[7]  = ~txt[7];
      txt[20] = ~txt[20];
      send_run(omss_pkg::MODE_TEXT, txt, 1);
      drain_reports();
   endtask

   // Pick from a small alphabet most of the time so windows actually match.
   function automatic sym_type pick_symbol(sym_type alpha [4], int unsigned n_alpha);
      if ($urandom_range(0, 9) == 0) return sym_type'($urandom);
      return alpha[$urandom_range(0, n_alpha - 1)];
   endfunction

   // Random sessions: a pattern, then a few texts with planted near-copies,
   // plus noise (open-pattern text, abandoned texts, stray items).
   task automatic test_random_sessions();
      sym_type       alpha [4];
      sym_type       pat   [PAT_CAP + 8];
      sym_queue_type txt;
      int unsigned   n_alpha;
      int unsigned   m;
      int unsigned   stored;
      int unsigned   tl;
      int unsigned   at;
      int unsigned   pos;
      int unsigned   base;
      int unsigned   next_drain;
      base       = items_taken;
      next_drain = items_taken + DRAIN_EVERY;
      while (items_taken - base < RANDOM_ITEMS) begin
         // some sessions run back to back with no idles on either side
         quiet   = ($urandom_range(0, 4) == 0);
         n_alpha = $urandom_range(1, 4);
         for (int i = 0; i < 4; i++) alpha[i] = sym_type'($urandom);
         case ($urandom_range(0, 9))
            0: m = $urandom_range(17, PAT_CAP);
            1: m = $urandom_range(PAT_CAP + 1, PAT_CAP + 8);
            default: m = $urandom_range(1, 8);
         endcase
         stored = (m < PAT_CAP) ? m : PAT_CAP;
         for (int i = 0; i < m; i++) begin
            pat[i] = pick_symbol(alpha, n_alpha);
            // text while the pattern is still open
            if ($urandom_range(0, 19) == 0)
               send_item(omss_pkg::MODE_TEXT, sym_type'($urandom), 1'($urandom));
            send_item(omss_pkg::MODE_PATTERN, pat[i], i == m - 1);
         end
         repeat ($urandom_range(1, 3)) begin
            txt.delete();
            tl = $urandom_range(1, stored + 6);
            for (int i = 0; i < tl; i++) txt.push_back(pick_symbol(alpha, n_alpha));
            // plant a copy with zero, one or two altered symbols
            if (tl >= stored && $urandom_range(0, 1) == 1) begin
               at = $urandom_range(0, tl - stored);
               for (int i = 0; i < stored; i++) txt[at + i] = pat[i];
               repeat ($urandom_range(0, 2)) begin
                  pos = at + $urandom_range(0, stored - 1);
                  txt[pos] = txt[pos] ^ sym_type'($urandom_range(1, 255));
               end
            end
            // now and then the text is left without its last symbol
            send_run(omss_pkg::MODE_TEXT, txt, $urandom_range(0, 7) != 0);
            if ($urandom_range(0, 9) == 0)
               send_item(1'($urandom), sym_type'($urandom), 1'($urandom));
         end
         if (items_taken >= next_drain) begin
            drain_reports();
            next_drain = items_taken + DRAIN_EVERY;
         end
      end
      quiet = 0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_mode   = omss_pkg::MODE_PATTERN;
      req_symbol = '0;
      req_last   = 1'b0;
      quiet      = 0;
      errors          = 0;
      items_taken     = 0;
      reports_checked = 0;
      hits_checked    = 0;
      misses_checked  = 0;
      pat_len    = 0;
      pat_closed = 0;
      for (int i = 0; i < PAT_CAP; i++) pat_mem[i] = '0;
      clear_search();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_pattern_overflow();
      test_random_sessions();

      drain_reports();
      repeat (8) @(negedge clock);
      $display("Covered %0d items, %0d reports (%0d hits, %0d no-hit), incl. pattern overflow",
               items_taken, reports_checked, hits_checked, misses_checked);
      if (errors == 0) begin
         $display("one_mismatch_substring_search verification clean");
      end else begin
         $display("one_mismatch_substring_search verification failed");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run (every item at worst-case
   // idle and stall).
   initial begin
      #2_000_000;
      $display("Timeout with %0d reports outstanding", pending_reports.size());
      $display("one_mismatch_substring_search verification failed");
      $finish;
   end

endmodule
